FILE: hdl/hat_pkg.sv
`default_nettype none

package hat_pkg;

   // Histogram geometry
   localparam int BIN_BITS  = 8;
   localparam int BINS      = 256;
   localparam int SCAN_LOW  = 2;

   // Field and register widths
   localparam int THR_BITS      = 8;
   localparam int AREA_BITS     = 20;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 20;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_AUTO_MODE   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FIXED_THR   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_AREA_TARGET = 2'd2;

   // Register reset values
   localparam logic [THR_BITS-1:0]  FIXED_THR_RESET   = 8'd128;
   localparam logic [AREA_BITS-1:0] AREA_TARGET_RESET = 20'd100;

   // Memory access requested by the scan sequencer
   typedef struct packed {
      logic                we;
      logic [BIN_BITS-1:0] waddr;
      logic [BIN_BITS-1:0] raddr;
   } mem_req_type;

   // Frame result handed from the sequencer to the output register
   typedef struct packed {
      logic                valid;
      logic [THR_BITS-1:0] threshold;
   } scan_out_type;

endpackage

`default_nettype wire

FILE: hdl/histogram_auto_threshold_top.sv
// Histogram auto threshold.
// Pixels enter on req_ (tdata = 8-bit gray level, tlast = last pixel of the
// frame) and are counted into a 256-bin histogram held in a synchronous RAM,
// one pixel per cycle while req_tready is high. A read-modify-write pipeline
// with one-deep forwarding handles back-to-back pixels hitting the same bin;
// counts saturate. After the last pixel of a frame, req_tready drops while
// the sequencer writes back the final count (WAIT), reads every bin (one RAM
// read port, one bin per cycle) while zeroing it (SWEEP), lets the last read
// data arrive (DRAIN) and hands the threshold to the rsp_ output register
// (EMIT). In fixed mode the sweep still runs and the fixed threshold is sent.
// A result waiting in the output register does not stop pixel intake; only
// the next frame's result waits for rsp_tready before the block reopens.
// Reset: registers take their reset values and a clearing sweep over every
// bin runs, followed by a drain step, with req_tready low; no result comes
// from it. Configuration (csr_) must be written only while the block is
// idle; the block itself does not enforce it.
`default_nettype none

module histogram_auto_threshold_top
   import hat_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] pixel
   input  wire logic                     req_tlast,   // last_of_frame
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [7:0]               rsp_tdata,   // [7:0] threshold
   // configuration writes
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic                  auto_mode_ff, auto_mode_in;
   logic [THR_BITS-1:0]   fixed_thr_ff, fixed_thr_in;
   logic [AREA_BITS-1:0]  area_target_ff, area_target_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [THR_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                  pix_ready;
   logic                  pix_acc;
   logic                  rsp_free;
   mem_req_type           scan_req;
   scan_out_type          scan_out;
   logic                  cnt_we;
   logic [BIN_BITS-1:0]   cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  ram_we;
   logic [BIN_BITS-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [BIN_BITS-1:0]   ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;

   assign req_tready = pix_ready;
   assign pix_acc    = req_tvalid && pix_ready;

   // Configuration registers
   always_comb begin
      auto_mode_in   = auto_mode_ff;
      fixed_thr_in   = fixed_thr_ff;
      area_target_in = area_target_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_AUTO_MODE:   auto_mode_in   = csr_wdata[0];
            REG_FIXED_THR:   fixed_thr_in   = csr_wdata[THR_BITS-1:0];
            REG_AREA_TARGET: area_target_in = csr_wdata[AREA_BITS-1:0];
            default: ;
         endcase
      end
   end

   // RAM read port: pixels while open, else sweep; write-back wins writes
   assign ram_raddr = pix_ready ? req_tdata[BIN_BITS-1:0] : scan_req.raddr;
   assign ram_we    = cnt_we || scan_req.we;
   assign ram_waddr = cnt_we ? cnt_waddr : scan_req.waddr;
   assign ram_wdata = cnt_we ? cnt_wdata : '0;

   hat_hist_ram #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hat_count #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_acc),
      .pix_bin   (req_tdata[BIN_BITS-1:0]),
      .rdata     (ram_rdata),
      .we        (cnt_we),
      .waddr     (cnt_waddr),
      .wdata     (cnt_wdata)
   );

   hat_scan #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .frame_end       (pix_acc && req_tlast),
      .auto_mode       (auto_mode_ff),
      .fixed_threshold (fixed_thr_ff),
      .area_target     (area_target_ff),
      .rdata           (ram_rdata),
      .out_free        (rsp_free),
      .pix_ready       (pix_ready),
      .mem_req         (scan_req),
      .scan_out        (scan_out)
   );

   // Output register
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = scan_out.valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = scan_out.valid ? scan_out.threshold : rsp_data_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_mode_ff   <= 1'b0;
         fixed_thr_ff   <= FIXED_THR_RESET;
         area_target_ff <= AREA_TARGET_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         auto_mode_ff   <= auto_mode_in;
         fixed_thr_ff   <= fixed_thr_in;
         area_target_ff <= area_target_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Pixel write-back and sweep never contend for the write port
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cnt_we && scan_req.we))
      else $error("pixel write-back overlaps sweep write");

   // Intake closes right after the last pixel of a frame
   a_close_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("intake still open after last pixel");

   // A frame result is only issued when the output register can take it
   a_result_room: assert property (@(posedge clock) disable iff (reset)
      scan_out.valid |-> rsp_free)
      else $error("result issued while output register is full");

endmodule

`default_nettype wire

FILE: hdl/hat_hist_ram.sv
`default_nettype none

module hat_hist_ram
   import hat_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [BIN_BITS-1:0]   waddr,
   input  wire logic [COUNT_BITS-1:0] wdata,
   input  wire logic [BIN_BITS-1:0]   raddr,
   output logic      [COUNT_BITS-1:0] rdata
);

   logic [COUNT_BITS-1:0] mem [BINS];
   logic [COUNT_BITS-1:0] rdata_ff;

   // One write and one registered read per cycle; same-address read returns old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/hat_count.sv
`default_nettype none

module hat_count
   import hat_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pix_valid,
   input  wire logic [BIN_BITS-1:0]   pix_bin,
   input  wire logic [COUNT_BITS-1:0] rdata,
   output logic                       we,
   output logic      [BIN_BITS-1:0]   waddr,
   output logic      [COUNT_BITS-1:0] wdata
);

   logic                  s1_vld_ff, s1_vld_in;
   logic [BIN_BITS-1:0]   s1_bin_ff, s1_bin_in;
   logic                  fwd_vld_ff, fwd_vld_in;
   logic [BIN_BITS-1:0]   fwd_bin_ff, fwd_bin_in;
   logic [COUNT_BITS-1:0] fwd_data_ff, fwd_data_in;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;

   // Read was issued at accept; the count arrives here in the following cycle
   assign s1_vld_in = pix_valid;
   assign s1_bin_in = pix_bin;

   // Previous cycle's write is not yet visible in the read data: forward it
   always_comb begin
      if (fwd_vld_ff && (fwd_bin_ff == s1_bin_ff)) begin
         cur_count = fwd_data_ff;
      end else begin
         cur_count = rdata;
      end
   end

   // Saturating increment
   assign new_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

   assign we    = s1_vld_ff;
   assign waddr = s1_bin_ff;
   assign wdata = new_count;

   assign fwd_vld_in  = s1_vld_ff;
   assign fwd_bin_in  = s1_bin_ff;
   assign fwd_data_in = new_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
      end
      s1_bin_ff   <= s1_bin_in;
      fwd_bin_ff  <= fwd_bin_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

`default_nettype wire

FILE: hdl/hat_scan.sv
`default_nettype none

module hat_scan
   import hat_pkg::*;
#(
   parameter int COUNT_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  frame_end,
   input  wire logic                  auto_mode,
   input  wire logic [THR_BITS-1:0]   fixed_threshold,
   input  wire logic [AREA_BITS-1:0]  area_target,
   input  wire logic [COUNT_BITS-1:0] rdata,
   input  wire logic                  out_free,
   output logic                       pix_ready,
   output mem_req_type                mem_req,
   output scan_out_type               scan_out
);

   localparam int SUM_BITS = (COUNT_BITS + BIN_BITS > AREA_BITS) ?
                             COUNT_BITS + BIN_BITS : AREA_BITS;

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_WAIT  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [BIN_BITS-1:0]   cnt_ff, cnt_in;
   logic                  emit_ff, emit_in;
   logic                  dv_ff, dv_in;
   logic [BIN_BITS-1:0]   dbin_ff, dbin_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                  found_ff, found_in;
   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [SUM_BITS-1:0]   sum_next;
   logic [BIN_BITS-1:0]   sweep_bin;

   // Sweep runs from the top bin down, zeroing each bin as it is read
   assign sweep_bin = BIN_BITS'(BINS - 1) - cnt_ff;
   assign sum_next  = sum_ff + SUM_BITS'(rdata);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      emit_in  = emit_ff;
      scan_out.valid     = 1'b0;
      scan_out.threshold = auto_mode ? thr_ff : fixed_threshold;
      case (state_ff)
         ST_RUN: begin
            if (frame_end) begin
               state_in = ST_WAIT;
               emit_in  = 1'b1;
            end
         end
         ST_WAIT: begin
            // last pixel's count is written back in this cycle
            state_in = ST_SWEEP;
            cnt_in   = '0;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + BIN_BITS'(1);
            if (cnt_ff == BIN_BITS'(BINS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = emit_ff ? ST_EMIT : ST_RUN;
         end
         ST_EMIT: begin
            if (out_free) begin
               scan_out.valid = 1'b1;
               state_in       = ST_RUN;
               emit_in        = 1'b0;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign pix_ready     = (state_ff == ST_RUN);
   assign mem_req.we    = (state_ff == ST_SWEEP);
   assign mem_req.waddr = sweep_bin;
   assign mem_req.raddr = sweep_bin;

   // Read data arrives in the cycle after its sweep address is issued
   assign dv_in   = (state_ff == ST_SWEEP);
   assign dbin_in = sweep_bin;

   // Running sum and threshold search
   always_comb begin
      sum_in   = sum_ff;
      found_in = found_ff;
      thr_in   = thr_ff;
      if (state_ff == ST_WAIT) begin
         sum_in   = '0;
         found_in = 1'b0;
         thr_in   = THR_BITS'(1);
      end else if (dv_ff && !found_ff && (dbin_ff >= BIN_BITS'(SCAN_LOW))) begin
         sum_in = sum_next;
         if (sum_next >= SUM_BITS'(area_target)) begin
            found_in = 1'b1;
         end else begin
            thr_in = THR_BITS'(dbin_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // clearing pass over the whole memory, no result
         state_ff <= ST_SWEEP;
         cnt_ff   <= '0;
         emit_ff  <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         dv_ff    <= dv_in;
      end
      dbin_ff  <= dbin_in;
      sum_ff   <= sum_in;
      found_ff <= found_in;
      thr_ff   <= thr_in;
   end

endmodule

`default_nettype wire
